[rtl/assert_macros.svh]
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while the active-low reset is asserted
`define CGB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);
// Clocked implication, next cycle
`define CGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/cgb_pkg.sv]
// Shared constants and types of the CSR graph builder
package cgb_pkg;
    localparam int MaxNodes  = 256;
    localparam int MaxEdges  = 1024;
    localparam int NodeW     = 8;
    localparam int KindW     = 4;
    localparam int CountW    = $clog2(MaxEdges + 1);
    localparam int EdgeAw    = $clog2(MaxEdges);
    localparam int NcW       = 9;

    localparam logic [2:0] ModeAppend  = 3'd0;
    localparam logic [2:0] ModeBuild   = 3'd1;
    localparam logic [2:0] ModeReadOff = 3'd2;
    localparam logic [2:0] ModeReadSlt = 3'd3;
    localparam logic [2:0] ModeClear   = 3'd4;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StFull  = 2'd1;
    localparam logic [1:0] StRange = 2'd2;
    localparam logic [1:0] StNoBld = 2'd3;

    localparam logic CfgNodeCount = 1'b0;
    localparam logic CfgReverse   = 1'b1;

    typedef struct packed {
        logic [NodeW-1:0] src;
        logic [NodeW-1:0] dst;
        logic [KindW-1:0] kind;
    } t_edge;
endpackage

[rtl/cgb_edge_store.sv]
// Edge list memory: one write port, one registered read port
module cgb_edge_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [cgb_pkg::EdgeAw-1:0]  i_waddr,
    input  cgb_pkg::t_edge              i_wdata,
    input  logic [cgb_pkg::EdgeAw-1:0]  i_raddr,
    output cgb_pkg::t_edge              o_rdata
);
    cgb_pkg::t_edge r_mem [cgb_pkg::MaxEdges];
    cgb_pkg::t_edge r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/csr_graph_builder.sv]
// CSR graph builder: edge loading, counting-sort build and slot reads
// Every request yields one response. Append, clear, unused modes and both reads pass
// from acceptance through a decide-and-fetch state (the registered memory read) to the
// response state, then the response is held until taken. A build is a sequencer over
// the offset, cursor and edge memories: it clears the n+1 offsets, reads each loaded
// edge to count degrees, forms the running sum over the offsets, reads each loaded edge
// again to scatter it into slots, then gives its response, where n is the node count
// (capped at 256). A new request is taken in the cycle that the previous response is
// taken or later, so a request is not taken before the previous one is through.
`include "assert_macros.svh"
module csr_graph_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // mode[2:0], src_node[10:3], to_node[18:11], edge_kind[22:19], position[32:23]
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // status[1:0], offset_value[12:2], neighbor_node[20:13], neighbor_kind[24:21],
    // edge_total[35:25]
    output logic [39:0] o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_wdata
);
    localparam int CW = cgb_pkg::CountW;
    localparam int AW = cgb_pkg::EdgeAw;
    localparam int NW = cgb_pkg::NodeW;
    localparam int KW = cgb_pkg::KindW;
    localparam int QW = cgb_pkg::NcW;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RESP    = 4'd1;
    localparam logic [3:0] S_CLR     = 4'd2;
    localparam logic [3:0] S_CNT_RD  = 4'd3;
    localparam logic [3:0] S_CNT_SRC = 4'd4;
    localparam logic [3:0] S_CNT_INC = 4'd5;
    localparam logic [3:0] S_PFX_RD  = 4'd6;
    localparam logic [3:0] S_PFX_ADD = 4'd7;
    localparam logic [3:0] S_SC_RD   = 4'd8;
    localparam logic [3:0] S_SC_SRC  = 4'd9;
    localparam logic [3:0] S_SC_PUT  = 4'd10;

    logic [2:0]    in_mode;
    logic [NW-1:0] in_from, in_to;
    logic [KW-1:0] in_kind;
    logic [9:0]    in_pos;
    assign in_mode = i_s_axis_tdata[2:0];
    assign in_from = i_s_axis_tdata[10:3];
    assign in_to   = i_s_axis_tdata[18:11];
    assign in_kind = i_s_axis_tdata[22:19];
    assign in_pos  = i_s_axis_tdata[32:23];

    logic [3:0]    r_state, n_state;
    logic [QW-1:0] r_node_cnt;
    logic          r_rev;
    logic [CW-1:0] r_loaded, n_loaded;
    logic [CW-1:0] r_placed, n_placed;
    logic          r_built, n_built;
    logic [QW-1:0] r_bnodes, n_bnodes;
    logic [QW-1:0] r_n, n_n;
    logic [QW-1:0] r_node, n_node;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_acc, n_acc;
    logic [NW-1:0] r_src, n_src;
    logic [NW-1:0] r_dst, n_dst;
    logic [KW-1:0] r_kind, n_kind;
    logic [2:0]    r_mode, n_mode;
    logic [1:0]    r_status, n_status;
    logic          r_ovalid, n_ovalid;
    logic [39:0]   r_odata, n_odata;

    logic [CW-1:0] r_offs [cgb_pkg::MaxNodes + 1];
    logic [CW-1:0] r_cur  [cgb_pkg::MaxNodes];
    logic [NW+KW-1:0] r_slot [cgb_pkg::MaxEdges];
    logic [CW-1:0] r_offs_q, r_cur_q;
    logic [NW+KW-1:0] r_slot_q;

    logic          offs_we, cur_we, slot_we, edge_we;
    logic [QW-1:0] offs_wa, offs_ra;
    logic [CW-1:0] offs_wd, cur_wd;
    logic [NW-1:0] cur_wa, cur_ra;
    logic [AW-1:0] slot_wa, slot_ra;
    logic [NW+KW-1:0] slot_wd;
    cgb_pkg::t_edge edge_wd, edge_q;

    logic          accept;
    logic [NW-1:0] e_src, e_dst;
    logic [CW-1:0] sum;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    assign e_src = r_rev ? edge_q.dst : edge_q.src;
    assign e_dst = r_rev ? edge_q.src : edge_q.dst;
    assign sum   = r_acc + r_offs_q;
    assign edge_wd = '{src: in_from, dst: in_to, kind: in_kind};

    cgb_edge_store u_edges (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_loaded[AW-1:0]),
        .i_wdata (edge_wd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (edge_q)
    );

    always_ff @(posedge i_clk) begin
        if (offs_we) begin
            r_offs[offs_wa] <= offs_wd;
        end
        if (cur_we) begin
            r_cur[cur_wa] <= cur_wd;
        end
        if (slot_we) begin
            r_slot[slot_wa] <= slot_wd;
        end
        r_offs_q <= r_offs[offs_ra];
        r_cur_q  <= r_cur[cur_ra];
        r_slot_q <= r_slot[slot_ra];
    end

    always_comb begin
        n_state = r_state;  n_loaded = r_loaded; n_placed = r_placed;
        n_built = r_built;  n_bnodes = r_bnodes; n_n = r_n;
        n_node = r_node;    n_idx = r_idx;       n_acc = r_acc;
        n_src = r_src;      n_dst = r_dst;       n_kind = r_kind;
        n_mode = r_mode;    n_status = r_status;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata = r_odata;
        offs_we = 1'b0; offs_wa = r_node; offs_wd = '0; offs_ra = r_node;
        cur_we = 1'b0;  cur_wa = r_src;   cur_wd = r_cur_q + CW'(1); cur_ra = e_src;
        slot_we = 1'b0; slot_wa = r_cur_q[AW-1:0]; slot_wd = {r_dst, r_kind};
        slot_ra = in_pos[AW-1:0];
        edge_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                offs_ra = in_pos[QW-1:0];
                if (accept) begin
                    n_mode = in_mode;
                    n_status = cgb_pkg::StOk;
                    n_state = S_RESP;
                    case (in_mode)
                        cgb_pkg::ModeAppend: begin
                            if (r_loaded >= CW'(cgb_pkg::MaxEdges)) begin
                                n_status = cgb_pkg::StFull;
                            end else begin
                                edge_we = 1'b1;
                                n_loaded = r_loaded + CW'(1);
                                n_built = 1'b0;
                            end
                        end
                        cgb_pkg::ModeBuild: begin
                            n_n = (r_node_cnt > QW'(cgb_pkg::MaxNodes)) ?
                                  QW'(cgb_pkg::MaxNodes) : r_node_cnt;
                            n_node = '0;
                            n_state = S_CLR;
                        end
                        cgb_pkg::ModeReadOff: begin
                            if (!r_built) begin
                                n_status = cgb_pkg::StNoBld;
                            end else if (in_pos > {1'b0, r_bnodes}) begin
                                n_status = cgb_pkg::StRange;
                            end
                        end
                        cgb_pkg::ModeReadSlt: begin
                            if (!r_built) begin
                                n_status = cgb_pkg::StNoBld;
                            end else if (CW'(in_pos) >= r_placed) begin
                                n_status = cgb_pkg::StRange;
                            end
                        end
                        cgb_pkg::ModeClear: begin
                            n_loaded = '0;
                            n_built = 1'b0;
                            n_bnodes = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RESP: begin
                n_ovalid = 1'b1;
                n_odata = '0;
                n_odata[1:0] = r_status;
                if (r_status == cgb_pkg::StOk && r_mode == cgb_pkg::ModeReadOff) begin
                    n_odata[12:2] = r_offs_q;
                end
                if (r_status == cgb_pkg::StOk && r_mode == cgb_pkg::ModeReadSlt) begin
                    n_odata[20:13] = r_slot_q[NW+KW-1:KW];
                    n_odata[24:21] = r_slot_q[KW-1:0];
                end
                n_odata[35:25] = r_built ? r_placed : r_loaded;
                n_state = S_IDLE;
            end
            S_CLR: begin
                offs_we = 1'b1;
                if (r_node == r_n) begin
                    n_idx = '0;
                    n_state = S_CNT_RD;
                end else begin
                    n_node = r_node + QW'(1);
                end
            end
            S_CNT_RD: begin
                if (r_idx == r_loaded) begin
                    n_node = '0;
                    n_acc = '0;
                    n_state = S_PFX_RD;
                end else begin
                    n_state = S_CNT_SRC;
                end
            end
            S_CNT_SRC: begin
                offs_ra = QW'(e_src) + QW'(1);
                n_src = e_src;
                if (QW'(e_src) < r_n) begin
                    n_state = S_CNT_INC;
                end else begin
                    n_idx = r_idx + CW'(1);
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_INC: begin
                offs_we = 1'b1;
                offs_wa = QW'(r_src) + QW'(1);
                offs_wd = r_offs_q + CW'(1);
                n_idx = r_idx + CW'(1);
                n_state = S_CNT_RD;
            end
            S_PFX_RD: begin
                n_state = S_PFX_ADD;
            end
            S_PFX_ADD: begin
                offs_we = 1'b1;
                offs_wd = sum;
                cur_wa = r_node[NW-1:0];
                cur_wd = sum;
                cur_we = (r_node < r_n);
                n_acc = sum;
                if (r_node == r_n) begin
                    n_placed = sum;
                    n_idx = '0;
                    n_state = S_SC_RD;
                end else begin
                    n_node = r_node + QW'(1);
                    n_state = S_PFX_RD;
                end
            end
            S_SC_RD: begin
                if (r_idx == r_loaded) begin
                    n_built = 1'b1;
                    n_bnodes = r_n;
                    n_state = S_RESP;
                end else begin
                    n_state = S_SC_SRC;
                end
            end
            S_SC_SRC: begin
                n_src = e_src;
                n_dst = e_dst;
                n_kind = edge_q.kind;
                if (QW'(e_src) < r_n) begin
                    n_state = S_SC_PUT;
                end else begin
                    n_idx = r_idx + CW'(1);
                    n_state = S_SC_RD;
                end
            end
            S_SC_PUT: begin
                slot_we = (r_cur_q < CW'(cgb_pkg::MaxEdges));
                cur_we = 1'b1;
                n_idx = r_idx + CW'(1);
                n_state = S_SC_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_node_cnt <= QW'(1);
            r_rev <= 1'b0;
            r_loaded <= '0;
            r_placed <= '0;
            r_built <= 1'b0;
            r_bnodes <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_loaded <= n_loaded;
            r_placed <= n_placed;
            r_built <= n_built;
            r_bnodes <= n_bnodes;
            r_ovalid <= n_ovalid;
            if (i_cfg_we && i_cfg_idx == cgb_pkg::CfgNodeCount) begin
                r_node_cnt <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_idx == cgb_pkg::CfgReverse) begin
                r_rev <= i_cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;     r_node <= n_node;   r_idx <= n_idx;   r_acc <= n_acc;
        r_src <= n_src; r_dst <= n_dst;     r_kind <= n_kind;
        r_mode <= n_mode; r_status <= n_status; r_odata <= n_odata;
    end

    `CGB_ASSERT(a_loaded_bound, r_loaded <= CW'(cgb_pkg::MaxEdges), "edge count overflow")
    `CGB_ASSERT(a_placed_bound, r_built |-> r_placed <= r_loaded, "placed exceeds loaded")
    `CGB_ASSERT_NEXT(a_resp_once, r_state == S_RESP, r_ovalid && r_state == S_IDLE,
        "response not raised")
endmodule
